/* rtl/rrt_tree_extend_nearest_top_defines.svh */
// Assertion macros shared by the tree extension RTL.
`ifndef RRT_TREE_EXTEND_NEAREST_TOP_DEFINES_SVH
`define RRT_TREE_EXTEND_NEAREST_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define RTEN_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("rten assertion failed");
`define RTEN_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rten assertion failed");
`else
`define RTEN_ASSERT(label, prop)
`define RTEN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* rtl/rten_pkg.sv */
// Types, constants and helpers of the tree extension block.
package rten_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int AW          = $clog2(MAX_NODES);
    localparam int CW          = $clog2(MAX_NODES + 1);
    localparam int IDX_W       = 10;
    localparam int DSQ_W       = 66;
    localparam int SQRT_STAGES = 34;
    localparam int RAD_W       = 2 * SQRT_STAGES;
    localparam int ROOT_W      = SQRT_STAGES;
    localparam int REM_W       = ROOT_W + 2;
    localparam int QUOT_W      = 32;

    typedef logic signed [31:0] t_coord;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_point;

    typedef enum logic [1:0] {
        CMD_ROOT   = 2'd0,
        CMD_EXTEND = 2'd1,
        CMD_TRACE  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_EXTENDED = 3'd0,
        STAT_GOAL     = 3'd1,
        STAT_LINKED   = 3'd2,
        STAT_BUDGET   = 3'd3,
        STAT_FULL     = 3'd4,
        STAT_ROOT     = 3'd5,
        STAT_TRACED   = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        CFG_GOAL_X    = 3'd0,
        CFG_GOAL_Y    = 3'd1,
        CFG_GOAL_Z    = 3'd2,
        CFG_STEP      = 3'd3,
        CFG_TOLERANCE = 3'd4,
        CFG_BUDGET    = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRACE,
        S_SEARCH,
        S_BEST,
        S_SQRT,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_STORE,
        S_GOAL,
        S_EMIT,
        S_EMIT2
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        t_point           pt;
        logic [IDX_W-1:0] parent;
        t_status          status;
        logic             last;
    } t_result;

    typedef struct packed {
        logic              vld;
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sqrt_stage;

    typedef struct packed {
        logic              start;
        logic [63:0]       num;
        logic [ROOT_W-1:0] den;
    } t_div_req;

    function automatic t_coord pt_axis(input t_point p, input logic [1:0] a);
        case (a)
            2'd0:    return p.x;
            2'd1:    return p.y;
            default: return p.z;
        endcase
    endfunction

    function automatic t_coord sat32(input logic signed [33:0] v);
        if (v > 34'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

/* rtl/rten_in_if.sv */
// Request channel of the tree extension block.
interface rten_in_if;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic signed [31:0]  point_x;
    logic signed [31:0]  point_y;
    logic signed [31:0]  point_z;
    logic                try_goal_link;
    logic [9:0]          query_index;

    modport source (output valid, command, point_x, point_y, point_z, try_goal_link,
                    query_index, input ready);
    modport sink (input valid, command, point_x, point_y, point_z, try_goal_link,
                  query_index, output ready);
endinterface

/* rtl/rten_out_if.sv */
// Result channel of the tree extension block.
interface rten_out_if;
    logic                valid;
    logic                ready;
    logic [9:0]          node_index;
    logic signed [31:0]  node_x;
    logic signed [31:0]  node_y;
    logic signed [31:0]  node_z;
    logic [9:0]          parent_index;
    logic [2:0]          status;
    logic                last_of_run;

    modport source (output valid, node_index, node_x, node_y, node_z, parent_index, status,
                    last_of_run, input ready);
    modport sink (input valid, node_index, node_x, node_y, node_z, parent_index, status,
                  last_of_run, output ready);
endinterface

/* rtl/rten_sqrt_cell.sv */
// One digit cell of the pipelined restoring square root.
module rten_sqrt_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rten_pkg::t_sqrt_stage i_stg,
    output rten_pkg::t_sqrt_stage o_stg
);

    logic [rten_pkg::REM_W+1:0] w_t;
    logic [rten_pkg::REM_W+1:0] w_trial;
    logic                       w_ge;
    rten_pkg::t_sqrt_stage      n_stg;
    rten_pkg::t_sqrt_stage      r_stg;

    always_comb begin
        w_t       = {i_stg.rem, i_stg.rad[rten_pkg::RAD_W-1 -: 2]};
        w_trial   = {2'b00, i_stg.root, 2'b01};
        w_ge      = (w_t >= w_trial);
        n_stg.vld = i_stg.vld;
        n_stg.rad = {i_stg.rad[rten_pkg::RAD_W-3:0], 2'b00};
        n_stg.rem = w_ge ? rten_pkg::REM_W'(w_t - w_trial) : w_t[rten_pkg::REM_W-1:0];
        n_stg.root = {i_stg.root[rten_pkg::ROOT_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        r_stg.rad  <= n_stg.rad;
        r_stg.rem  <= n_stg.rem;
        r_stg.root <= n_stg.root;
        if (!i_rst_n) begin
            r_stg.vld <= 1'b0;
        end else begin
            r_stg.vld <= n_stg.vld;
        end
    end

    assign o_stg = r_stg;

endmodule

/* rtl/rten_sqrt_chain.sv */
// Row of square root cells, one result bit per cell.
module rten_sqrt_chain (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_vld,
    input  logic [rten_pkg::DSQ_W-1:0]    i_rad,
    output logic                          o_vld,
    output logic [rten_pkg::ROOT_W-1:0]   o_root
);

    rten_pkg::t_sqrt_stage w_stg [rten_pkg::SQRT_STAGES+1];

    assign w_stg[0].vld  = i_vld;
    assign w_stg[0].rad  = rten_pkg::RAD_W'(i_rad);
    assign w_stg[0].rem  = '0;
    assign w_stg[0].root = '0;

    for (genvar g = 0; g < rten_pkg::SQRT_STAGES; g++) begin : g_cell
        rten_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stg   (w_stg[g]),
            .o_stg   (w_stg[g+1])
        );
    end

    assign o_vld  = w_stg[rten_pkg::SQRT_STAGES].vld;
    assign o_root = w_stg[rten_pkg::SQRT_STAGES].root;

endmodule

/* rtl/rten_dist.sv */
// Three stage squared distance pipeline between two points.
module rten_dist (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_vld,
    input  logic [rten_pkg::AW-1:0]      i_tag,
    input  rten_pkg::t_point             i_a,
    input  rten_pkg::t_point             i_b,
    output logic                         o_vld,
    output logic [rten_pkg::AW-1:0]      o_tag,
    output logic [rten_pkg::DSQ_W-1:0]   o_dsq
);

    logic [2:0]                r_vld;
    logic [rten_pkg::AW-1:0]   r_tag [3];
    logic [31:0]               r_mag [3];
    logic [63:0]               r_sq  [3];
    logic [rten_pkg::DSQ_W-1:0] r_sum;
    logic signed [32:0]        w_diff [3];
    logic [31:0]               w_mag  [3];

    always_comb begin
        w_diff[0] = {i_a.x[31], i_a.x} - {i_b.x[31], i_b.x};
        w_diff[1] = {i_a.y[31], i_a.y} - {i_b.y[31], i_b.y};
        w_diff[2] = {i_a.z[31], i_a.z} - {i_b.z[31], i_b.z};
        for (int k = 0; k < 3; k++) begin
            w_mag[k] = w_diff[k][32] ? 32'(-w_diff[k]) : w_diff[k][31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[1:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        for (int k = 0; k < 3; k++) begin
            r_mag[k] <= w_mag[k];
            r_sq[k]  <= 64'(r_mag[k]) * 64'(r_mag[k]);
        end
        r_sum <= rten_pkg::DSQ_W'(r_sq[0]) + rten_pkg::DSQ_W'(r_sq[1])
               + rten_pkg::DSQ_W'(r_sq[2]);
    end

    assign o_vld = r_vld[2];
    assign o_tag = r_tag[2];
    assign o_dsq = r_sum;

endmodule

/* rtl/rten_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
`include "rrt_tree_extend_nearest_top_defines.svh"
module rten_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rten_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [rten_pkg::QUOT_W-1:0]   o_quot
);

    logic                         r_busy;
    logic                         r_done;
    logic [5:0]                   r_cnt;
    logic [rten_pkg::ROOT_W-1:0]  r_rem;
    logic [rten_pkg::ROOT_W-1:0]  r_den;
    logic [rten_pkg::QUOT_W-1:0]  r_q;
    logic [rten_pkg::ROOT_W:0]    w_t;
    logic                         w_ge;

    always_comb begin
        w_t  = {r_rem, r_q[rten_pkg::QUOT_W-1]};
        w_ge = (w_t >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(rten_pkg::QUOT_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            // high half of the dividend is known to sit below the divisor
            r_rem <= rten_pkg::ROOT_W'(i_req.num[63:32]);
            r_q   <= i_req.num[31:0];
            r_den <= i_req.den;
        end else if (r_busy) begin
            r_rem <= w_ge ? rten_pkg::ROOT_W'(w_t - {1'b0, r_den}) : w_t[rten_pkg::ROOT_W-1:0];
            r_q   <= {r_q[rten_pkg::QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

    `RTEN_ASSERT(a_no_restart, i_req.start |-> !r_busy)

endmodule

/* rtl/rrt_tree_extend_nearest_top.sv */
// Top level of the RRT tree extension block with exhaustive nearest search.
//
//  channel   dir  handshake             payload
//  i_req     in   valid/ready           command, point_x/y/z, try_goal_link, query_index
//  o_rsp     out  valid/ready           node_index, node_x/y/z, parent_index, status,
//                                       last_of_run
//  i_cfg_*   in   write enable only     register index, 32 bit data
//
// Extend reads every node of the tree, one node store read per cycle, through the distance
// pipeline, then takes the root in the square root cell row and, unless the root is zero,
// runs three divisions, one per axis.
// Reset is synchronous and active low; the node store is not cleared, but the count is.
// A result waits in the output register while the next request is taken; the block
// holds a new result until the output register is free.
`include "rrt_tree_extend_nearest_top_defines.svh"
module rrt_tree_extend_nearest_top (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rten_in_if.sink               i_req,
    rten_out_if.source            o_rsp,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [31:0]           i_cfg_data
);

    // node store
    logic [95:0]                  mem_coord [rten_pkg::MAX_NODES];
    logic [rten_pkg::IDX_W-1:0]   mem_par   [rten_pkg::MAX_NODES];
    logic                         mem_we;
    logic [rten_pkg::AW-1:0]      mem_waddr;
    rten_pkg::t_point             mem_wdata;
    logic [rten_pkg::IDX_W-1:0]   mem_wpar;
    logic [rten_pkg::AW-1:0]      raddr;
    rten_pkg::t_point             r_rd_coord;
    logic [rten_pkg::IDX_W-1:0]   r_rd_par;

    // configuration
    rten_pkg::t_point             r_goal;
    logic [30:0]                  r_step;
    logic [30:0]                  r_tol;
    logic [9:0]                   r_budget;
    logic [61:0]                  r_tol2;

    // control state
    rten_pkg::t_state             r_state, n_state;
    logic [rten_pkg::CW-1:0]      r_count;
    logic [9:0]                   r_iters;
    logic [rten_pkg::CW-1:0]      r_addr;
    logic [rten_pkg::CW-1:0]      r_ndone;
    logic                         r_rd_vld;
    logic [rten_pkg::AW-1:0]      r_rd_tag;
    logic                         r_pend2;
    logic                         r_ov;

    // request and datapath
    rten_pkg::t_point             r_pt;
    logic                         r_link;
    logic                         r_qok;
    logic [rten_pkg::IDX_W-1:0]   r_q;
    logic [rten_pkg::AW-1:0]      r_best;
    logic [rten_pkg::DSQ_W-1:0]   r_bd;
    logic [rten_pkg::ROOT_W-1:0]  r_norm;
    rten_pkg::t_point             r_base;
    rten_pkg::t_point             r_nc;
    logic [1:0]                   r_axis;
    logic                         r_neg;
    logic [62:0]                  r_prod;
    logic [rten_pkg::AW-1:0]      r_ni;
    rten_pkg::t_result            r_res, r_res2, r_out;

    logic                         req_acc;
    logic                         can_load;
    logic                         out_load;
    logic                         no_budget;
    logic                         is_full;
    logic                         reached;
    logic                         link_ok;
    rten_pkg::t_point             req_pt;
    rten_pkg::t_coord             ax_s, ax_b;
    logic signed [32:0]           ax_diff;
    logic [31:0]                  ax_mag;
    logic signed [33:0]           ax_off, ax_sum;

    logic                         dist_vld;
    rten_pkg::t_point             dist_a, dist_b;
    logic                         d_vld;
    logic [rten_pkg::AW-1:0]      d_tag;
    logic [rten_pkg::DSQ_W-1:0]   d_dsq;
    logic                         sq_vld;
    logic [rten_pkg::ROOT_W-1:0]  sq_root;
    rten_pkg::t_div_req           div_req;
    logic                         div_done;
    logic [rten_pkg::QUOT_W-1:0]  div_quot;

    assign i_req.ready = (r_state == rten_pkg::S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;
    assign can_load    = !r_ov || o_rsp.ready;
    assign req_pt      = '{x: i_req.point_x, y: i_req.point_y, z: i_req.point_z};
    assign no_budget   = (r_iters == '0) || (r_count == '0);
    assign is_full     = (r_count >= rten_pkg::CW'(rten_pkg::MAX_NODES));
    assign reached     = (d_dsq <= rten_pkg::DSQ_W'(r_tol2));
    assign link_ok     = r_link && (r_count < rten_pkg::CW'(rten_pkg::MAX_NODES));

    // per axis step arithmetic
    always_comb begin
        ax_s    = rten_pkg::pt_axis(r_pt, r_axis);
        ax_b    = rten_pkg::pt_axis(r_base, r_axis);
        ax_diff = {ax_s[31], ax_s} - {ax_b[31], ax_b};
        ax_mag  = ax_diff[32] ? 32'(-ax_diff) : ax_diff[31:0];
        ax_off  = r_neg ? -$signed({2'b00, div_quot}) : $signed({2'b00, div_quot});
        ax_sum  = $signed({{2{ax_b[31]}}, ax_b}) + ax_off;
    end

    // shared units
    assign dist_vld = r_rd_vld || (r_state == rten_pkg::S_STORE);
    assign dist_a   = (r_state == rten_pkg::S_STORE) ? r_nc : r_rd_coord;
    assign dist_b   = (r_state == rten_pkg::S_STORE) ? r_goal : r_pt;

    rten_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (dist_vld),
        .i_tag   (r_rd_tag),
        .i_a     (dist_a),
        .i_b     (dist_b),
        .o_vld   (d_vld),
        .o_tag   (d_tag),
        .o_dsq   (d_dsq)
    );

    rten_sqrt_chain u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_state == rten_pkg::S_BEST),
        .i_rad   (r_bd),
        .o_vld   (sq_vld),
        .o_root  (sq_root)
    );

    assign div_req.start = (r_state == rten_pkg::S_DSTART);
    assign div_req.num   = {1'b0, r_prod} + 64'(r_norm[rten_pkg::ROOT_W-1:1]);
    assign div_req.den   = r_norm;

    rten_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rten_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state, store port and output strobe
    always_comb begin
        n_state   = r_state;
        mem_we    = 1'b0;
        mem_waddr = r_count[rten_pkg::AW-1:0];
        mem_wdata = r_nc;
        mem_wpar  = rten_pkg::IDX_W'(r_best);
        raddr     = r_best;
        out_load  = 1'b0;
        unique case (r_state)
            rten_pkg::S_IDLE: begin
                raddr = rten_pkg::AW'(i_req.query_index);
                if (req_acc) begin
                    unique case (rten_pkg::t_cmd'(i_req.command))
                        rten_pkg::CMD_ROOT: begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = req_pt;
                            mem_wpar  = '0;
                            n_state   = rten_pkg::S_EMIT;
                        end
                        rten_pkg::CMD_TRACE: n_state = rten_pkg::S_TRACE;
                        rten_pkg::CMD_EXTEND: begin
                            n_state = (no_budget || is_full) ? rten_pkg::S_EMIT
                                                             : rten_pkg::S_SEARCH;
                        end
                        default: n_state = rten_pkg::S_IDLE;
                    endcase
                end
            end
            rten_pkg::S_TRACE: n_state = rten_pkg::S_EMIT;
            rten_pkg::S_SEARCH: begin
                raddr = r_addr[rten_pkg::AW-1:0];
                if (r_ndone == r_count) begin
                    n_state = rten_pkg::S_BEST;
                end
            end
            rten_pkg::S_BEST: n_state = rten_pkg::S_SQRT;
            rten_pkg::S_SQRT: begin
                if (sq_vld) begin
                    n_state = (sq_root == '0) ? rten_pkg::S_STORE : rten_pkg::S_MUL;
                end
            end
            rten_pkg::S_MUL:    n_state = rten_pkg::S_DSTART;
            rten_pkg::S_DSTART: n_state = rten_pkg::S_DIV;
            rten_pkg::S_DIV: begin
                if (div_done) begin
                    n_state = (r_axis == 2'd2) ? rten_pkg::S_STORE : rten_pkg::S_MUL;
                end
            end
            rten_pkg::S_STORE: begin
                mem_we  = 1'b1;
                n_state = rten_pkg::S_GOAL;
            end
            rten_pkg::S_GOAL: begin
                if (d_vld) begin
                    if (!reached && link_ok) begin
                        mem_we    = 1'b1;
                        mem_wdata = r_goal;
                        mem_wpar  = rten_pkg::IDX_W'(r_ni);
                    end
                    n_state = rten_pkg::S_EMIT;
                end
            end
            rten_pkg::S_EMIT: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = r_pend2 ? rten_pkg::S_EMIT2 : rten_pkg::S_IDLE;
                end
            end
            rten_pkg::S_EMIT2: begin
                if (can_load) begin
                    out_load = 1'b1;
                    n_state  = rten_pkg::S_IDLE;
                end
            end
            default: n_state = rten_pkg::S_IDLE;
        endcase
    end

    // node store, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_coord[mem_waddr] <= mem_wdata;
            mem_par[mem_waddr]   <= mem_wpar;
        end
        r_rd_coord <= mem_coord[raddr];
        r_rd_par   <= mem_par[raddr];
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal   <= '0;
            r_step   <= 31'd65536;
            r_tol    <= 31'd65536;
            r_budget <= 10'd1000;
        end else if (i_cfg_we) begin
            unique case (rten_pkg::t_cfg_idx'(i_cfg_idx))
                rten_pkg::CFG_GOAL_X:    r_goal.x <= i_cfg_data;
                rten_pkg::CFG_GOAL_Y:    r_goal.y <= i_cfg_data;
                rten_pkg::CFG_GOAL_Z:    r_goal.z <= i_cfg_data;
                rten_pkg::CFG_STEP:      r_step   <= i_cfg_data[30:0];
                rten_pkg::CFG_TOLERANCE: r_tol    <= i_cfg_data[30:0];
                rten_pkg::CFG_BUDGET:    r_budget <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tol2 <= 62'(r_tol) * 62'(r_tol);
    end

    // control counters and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_iters  <= '0;
            r_addr   <= '0;
            r_ndone  <= '0;
            r_rd_vld <= 1'b0;
            r_pend2  <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_rd_vld <= (r_state == rten_pkg::S_SEARCH) && (r_addr < r_count);
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                rten_pkg::S_IDLE: begin
                    r_addr  <= '0;
                    r_ndone <= '0;
                    r_pend2 <= 1'b0;
                    if (req_acc && (rten_pkg::t_cmd'(i_req.command) == rten_pkg::CMD_ROOT))
                    begin
                        r_count <= rten_pkg::CW'(1);
                        r_iters <= r_budget;
                    end
                end
                rten_pkg::S_SEARCH: begin
                    if (r_addr < r_count) begin
                        r_addr <= r_addr + 1'b1;
                    end
                    if (d_vld) begin
                        r_ndone <= r_ndone + 1'b1;
                    end
                end
                rten_pkg::S_STORE: begin
                    r_count <= r_count + 1'b1;
                    r_iters <= r_iters - 1'b1;
                end
                rten_pkg::S_GOAL: begin
                    if (d_vld && !reached && link_ok) begin
                        r_count <= r_count + 1'b1;
                        r_pend2 <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_tag <= r_addr[rten_pkg::AW-1:0];
        if (out_load) begin
            r_out <= (r_state == rten_pkg::S_EMIT2) ? r_res2 : r_res;
        end
        unique case (r_state)
            rten_pkg::S_IDLE: begin
                r_pt   <= req_pt;
                r_link <= i_req.try_goal_link;
                r_q    <= i_req.query_index;
                r_qok  <= (rten_pkg::CW'(i_req.query_index) < r_count);
                if (rten_pkg::t_cmd'(i_req.command) == rten_pkg::CMD_ROOT) begin
                    r_res <= '{idx: '0, pt: req_pt, parent: '0,
                               status: rten_pkg::STAT_ROOT, last: 1'b1};
                end else begin
                    r_res <= '{idx: '0, pt: '0, parent: '0,
                               status: no_budget ? rten_pkg::STAT_BUDGET
                                                 : rten_pkg::STAT_FULL,
                               last: 1'b1};
                end
            end
            rten_pkg::S_TRACE: begin
                if (r_qok) begin
                    r_res <= '{idx: r_q, pt: r_rd_coord, parent: r_rd_par,
                               status: rten_pkg::STAT_TRACED, last: 1'b1};
                end else begin
                    r_res <= '{idx: r_q, pt: '0, parent: r_q,
                               status: rten_pkg::STAT_TRACED, last: 1'b1};
                end
            end
            rten_pkg::S_SEARCH: begin
                // strict compare keeps the lowest index on ties
                if (d_vld && ((d_tag == '0) || (d_dsq < r_bd))) begin
                    r_bd   <= d_dsq;
                    r_best <= d_tag;
                end
            end
            rten_pkg::S_SQRT: begin
                r_norm <= sq_root;
                r_base <= r_rd_coord;
                r_nc   <= r_rd_coord;
                r_axis <= 2'd0;
            end
            rten_pkg::S_MUL: begin
                r_neg  <= ax_diff[32];
                r_prod <= 63'(ax_mag) * 63'(r_step);
            end
            rten_pkg::S_DIV: begin
                if (div_done) begin
                    case (r_axis)
                        2'd0:    r_nc.x <= rten_pkg::sat32(ax_sum);
                        2'd1:    r_nc.y <= rten_pkg::sat32(ax_sum);
                        default: r_nc.z <= rten_pkg::sat32(ax_sum);
                    endcase
                    r_axis <= r_axis + 1'b1;
                end
            end
            rten_pkg::S_STORE: begin
                r_ni <= r_count[rten_pkg::AW-1:0];
            end
            rten_pkg::S_GOAL: begin
                if (d_vld) begin
                    r_res <= '{idx: rten_pkg::IDX_W'(r_ni), pt: r_nc,
                               parent: rten_pkg::IDX_W'(r_best),
                               status: reached ? rten_pkg::STAT_GOAL
                                               : rten_pkg::STAT_EXTENDED,
                               last: reached || !link_ok};
                    r_res2 <= '{idx: rten_pkg::IDX_W'(r_count), pt: r_goal,
                                parent: rten_pkg::IDX_W'(r_ni),
                                status: rten_pkg::STAT_LINKED, last: 1'b1};
                end
            end
            default: ;
        endcase
    end

    assign o_rsp.valid        = r_ov;
    assign o_rsp.node_index   = r_out.idx;
    assign o_rsp.node_x       = r_out.pt.x;
    assign o_rsp.node_y       = r_out.pt.y;
    assign o_rsp.node_z       = r_out.pt.z;
    assign o_rsp.parent_index = r_out.parent;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.last_of_run  = r_out.last;

    `RTEN_ASSERT(a_count_bound, r_count <= rten_pkg::CW'(rten_pkg::MAX_NODES))
    `RTEN_ASSERT(a_sqrt_in_state, sq_vld |-> (r_state == rten_pkg::S_SQRT))
    `RTEN_ASSERT_NEXT(a_store_grows, (r_state == rten_pkg::S_STORE), (r_count == $past(r_count) + 1'b1))

endmodule

/* sim/rrt_tree_extend_nearest_top_tb.sv */
// Self-checking testbench for the RRT tree extension block with exhaustive nearest search.
module rrt_tree_extend_nearest_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rten_pkg::*;

    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int CMD_NONE = 3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] pz;
        logic               link;
        logic [9:0]         query;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_data = '0;

    rten_in_if  req_if ();
    rten_out_if rsp_if ();

    rrt_tree_extend_nearest_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if.sink),
        .o_rsp      (rsp_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Mirror of the tree and of the registers.
    t_point      tree_pts [MAX_NODES];
    logic [9:0]  tree_par [MAX_NODES];
    int unsigned tree_size;
    int unsigned budget_left;
    t_point      goal_pt;
    logic [30:0] step_len;
    logic [30:0] goal_tol;
    logic [9:0]  budget_cfg;

    t_request pending_reqs[$];
    t_result  expected_results[$];
    int       failures;
    bit       hold_off;
    bit       req_taken;
    longint   cycle_count;

    function automatic void add_req(input t_request r);
        pending_reqs = {pending_reqs, r};
    endfunction

    function automatic void add_expect(input t_result r);
        expected_results = {expected_results, r};
    endfunction

    function automatic logic [65:0] dist_sq(input t_point a, input t_point b);
        logic signed [32:0] dx, dy, dz;
        logic [32:0] mx, my, mz;
        dx = 33'(a.x) - 33'(b.x);
        dy = 33'(a.y) - 33'(b.y);
        dz = 33'(a.z) - 33'(b.z);
        mx = dx < 0 ? -dx : dx;
        my = dy < 0 ? -dy : dy;
        mz = dz < 0 ? -dz : dz;
        return 66'(mx) * 66'(mx) + 66'(my) * 66'(my) + 66'(mz) * 66'(mz);
    endfunction

    function automatic logic [33:0] floor_root(input logic [65:0] v);
        logic [33:0] r;
        logic [33:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            if (68'(c) * 68'(c) <= 68'(v)) r = c;
        end
        return r;
    endfunction

    function automatic t_coord step_axis(input t_coord base, input t_coord tgt,
                                         input logic [33:0] norm);
        logic signed [32:0] d;
        logic [32:0] m;
        logic [95:0] off;
        logic signed [97:0] sum;
        d = 33'(tgt) - 33'(base);
        m = d < 0 ? -d : d;
        off = (96'(m) * 96'(step_len) + 96'(norm / 2)) / 96'(norm);
        sum = d < 0 ? 98'(base) - 98'(off) : 98'(base) + 98'(off);
        if (sum > 98'sd2147483647) return 32'sh7FFFFFFF;
        if (sum < -98'sd2147483648) return 32'sh80000000;
        return sum[31:0];
    endfunction

    function automatic t_result mk_result(input int unsigned idx, input t_point p,
                                          input int unsigned par, input t_status st,
                                          input logic last);
        t_result r;
        r.idx = idx[9:0];
        r.pt = p;
        r.parent = par[9:0];
        r.status = st;
        r.last = last;
        return r;
    endfunction

    // Work out the results of one accepted request and advance the mirror.
    task automatic predict_tree_step(input t_request rq);
        t_point s, nc, zero;
        int unsigned best, ni, gi;
        logic [65:0] bd, d;
        logic [33:0] norm;
        zero = '0;
        s.x = rq.px; s.y = rq.py; s.z = rq.pz;
        case (rq.command)
            CMD_ROOT: begin
                tree_pts[0] = s;
                tree_par[0] = '0;
                tree_size = 1;
                budget_left = budget_cfg;
                add_expect(mk_result(0, s, 0, STAT_ROOT, 1'b1));
            end
            CMD_TRACE: begin
                if (rq.query < tree_size)
                    add_expect(mk_result(rq.query, tree_pts[rq.query],
                        tree_par[rq.query], STAT_TRACED, 1'b1));
                else
                    add_expect(mk_result(rq.query, zero, rq.query, STAT_TRACED, 1'b1));
            end
            CMD_EXTEND: begin
                if (budget_left == 0 || tree_size == 0) begin
                    add_expect(mk_result(0, zero, 0, STAT_BUDGET, 1'b1));
                end else if (tree_size >= MAX_NODES) begin
                    add_expect(mk_result(0, zero, 0, STAT_FULL, 1'b1));
                end else begin
                    best = 0;
                    bd = dist_sq(tree_pts[0], s);
                    for (int unsigned i = 1; i < tree_size; i++) begin
                        d = dist_sq(tree_pts[i], s);
                        if (d < bd) begin
                            bd = d;
                            best = i;
                        end
                    end
                    norm = floor_root(bd);
                    if (norm == 0) begin
                        nc = tree_pts[best];
                    end else begin
                        nc.x = step_axis(tree_pts[best].x, s.x, norm);
                        nc.y = step_axis(tree_pts[best].y, s.y, norm);
                        nc.z = step_axis(tree_pts[best].z, s.z, norm);
                    end
                    ni = tree_size;
                    tree_pts[ni] = nc;
                    tree_par[ni] = best[9:0];
                    tree_size++;
                    budget_left--;
                    if (dist_sq(nc, goal_pt) <= 66'(goal_tol) * 66'(goal_tol)) begin
                        add_expect(mk_result(ni, nc, best, STAT_GOAL, 1'b1));
                    end else if (rq.link && tree_size < MAX_NODES) begin
                        gi = tree_size;
                        tree_pts[gi] = goal_pt;
                        tree_par[gi] = ni[9:0];
                        tree_size++;
                        add_expect(mk_result(ni, nc, best, STAT_EXTENDED, 1'b0));
                        add_expect(mk_result(gi, goal_pt, ni, STAT_LINKED, 1'b1));
                    end else begin
                        add_expect(mk_result(ni, nc, best, STAT_EXTENDED, 1'b1));
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Short gaps mostly, a long one now and then.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 20);
        return $urandom_range(40, 150);
    endfunction

    // Driver: offer queued requests, with random gaps between them.
    int send_gap;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            send_gap <= 0;
        end else if (req_if.valid && !req_taken) begin
            // hold the offered transaction
        end else if (send_gap > 0) begin
            req_if.valid <= 1'b0;
            send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0) begin
            t_request rq;
            rq = pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_if.command <= rq.command;
            req_if.point_x <= rq.px;
            req_if.point_y <= rq.py;
            req_if.point_z <= rq.pz;
            req_if.try_goal_link <= rq.link;
            req_if.query_index <= rq.query;
            send_gap <= gap_len();
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    // Accepted requests feed the predictor at the rising edge.
    always @(posedge i_clk) begin
        req_taken <= i_rst_n && req_if.valid && req_if.ready;
        if (i_rst_n && req_if.valid && req_if.ready) begin
            t_request rq;
            rq.command = req_if.command;
            rq.px = req_if.point_x;
            rq.py = req_if.point_y;
            rq.pz = req_if.point_z;
            rq.link = req_if.try_goal_link;
            rq.query = req_if.query_index;
            predict_tree_step(rq);
        end
    end

    // Receiver stalls: random, or a long hold-off when asked.
    int stall_len;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            stall_len <= 0;
        end else if (hold_off) begin
            rsp_if.ready <= 1'b0;
        end else if (stall_len > 0) begin
            rsp_if.ready <= 1'b0;
            stall_len <= stall_len - 1;
        end else begin
            rsp_if.ready <= 1'b1;
            stall_len <= ($urandom_range(0, 2) == 0) ? gap_len() : 0;
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            t_result got;
            t_result exp_r;
            got = mk_result(rsp_if.node_index, '{rsp_if.node_x, rsp_if.node_y, rsp_if.node_z},
                            rsp_if.parent_index, t_status'(rsp_if.status), rsp_if.last_of_run);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                failures++;
            end else begin
                exp_r = expected_results.pop_front();
                if (got.idx !== exp_r.idx)
                    $display("%0t: node_index expected %0d actual %0d", $time, exp_r.idx, got.idx);
                if (got.pt.x !== exp_r.pt.x)
                    $display("%0t: node_x expected %0d actual %0d", $time, exp_r.pt.x, got.pt.x);
                if (got.pt.y !== exp_r.pt.y)
                    $display("%0t: node_y expected %0d actual %0d", $time, exp_r.pt.y, got.pt.y);
                if (got.pt.z !== exp_r.pt.z)
                    $display("%0t: node_z expected %0d actual %0d", $time, exp_r.pt.z, got.pt.z);
                if (got.parent !== exp_r.parent)
                    $display("%0t: parent_index expected %0d actual %0d", $time,
                             exp_r.parent, got.parent);
                if (got.status !== exp_r.status)
                    $display("%0t: status expected %0d actual %0d", $time,
                             exp_r.status, got.status);
                if (got.last !== exp_r.last)
                    $display("%0t: last_of_run expected %0d actual %0d", $time,
                             exp_r.last, got.last);
                if (got !== exp_r) failures++;
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic t_request make_req(input int cmd, input t_coord x, input t_coord y,
                                          input t_coord z, input logic link,
                                          input logic [9:0] q);
        t_request r;
        r.command = cmd[1:0];
        r.px = x; r.py = y; r.pz = z;
        r.link = link;
        r.query = q;
        return r;
    endfunction

    // Sample inside the working area around the origin.
    function automatic t_coord near_coord();
        return $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endfunction

    // Sample near the working area mostly, full range sometimes.
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return near_coord();
        endcase
    endfunction

    // Trace index that never touches an unwritten entry: in range or the top index 1023.
    function automatic logic [9:0] rand_query(input int unsigned size_now);
        if (size_now > 0 && $urandom_range(0, 4) != 0)
            return 10'($urandom_range(0, size_now - 1));
        return 10'd1023;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_GOAL_X:    goal_pt.x = val;
            CFG_GOAL_Y:    goal_pt.y = val;
            CFG_GOAL_Z:    goal_pt.z = val;
            CFG_STEP:      step_len = val[30:0];
            CFG_TOLERANCE: goal_tol = val[30:0];
            CFG_BUDGET:    budget_cfg = val[9:0];
            default: ;
        endcase
    endtask

    // Wait until everything sent has come back, then let an extend drain.
    task automatic drain();
        while (pending_reqs.size() > 0 || req_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (1500) @(posedge i_clk);
    endtask

    // Random phase; tracks an estimate of tree size to keep traces legal.
    task automatic random_phase(input int count, input int unsigned root_budget);
        int unsigned est;
        int r;
        est = 0;
        add_req(make_req(CMD_ROOT, rand_coord(), rand_coord(), rand_coord(), 1'b0, '0));
        est = 1;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                add_req(make_req(CMD_EXTEND, rand_coord(), rand_coord(), rand_coord(),
                                 1'($urandom_range(0, 1)), '0));
            end else if (r < 88) begin
                // est is a lower bound on the tree size
                add_req(make_req(CMD_TRACE, rand_coord(), rand_coord(), rand_coord(),
                                 1'($urandom_range(0, 1)), rand_query(est)));
            end else if (r < 94) begin
                add_req(make_req(CMD_ROOT, rand_coord(), rand_coord(), rand_coord(),
                                 1'($urandom_range(0, 1)), '0));
                est = 1;
            end else begin
                add_req(make_req(CMD_NONE, $urandom, $urandom, $urandom,
                                 1'($urandom_range(0, 1)), 10'($urandom)));
                n--;
                continue;
            end
            if (r < 70 && est < root_budget + 1) est++;
        end
    endtask

    initial begin
        t_coord g;
        failures = 0;
        hold_off = 1'b0;
        req_taken = 1'b0;
        cycle_count = 0;
        req_if.valid = 1'b0;
        req_if.command = '0;
        req_if.point_x = '0;
        req_if.point_y = '0;
        req_if.point_z = '0;
        req_if.try_goal_link = 1'b0;
        req_if.query_index = '0;
        rsp_if.ready = 1'b0;
        goal_pt = '0;
        step_len = 31'd65536;
        goal_tol = 31'd65536;
        budget_cfg = 10'd1000;
        tree_size = 0;
        budget_left = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extend before any root, a trace past the end, unused command.
        add_req(make_req(CMD_EXTEND, 5, 6, 7, 1'b1, '0));
        add_req(make_req(CMD_TRACE, 0, 0, 0, 1'b0, 10'd1023));
        add_req(make_req(CMD_NONE, -1, -1, -1, 1'b1, 10'd1023));
        // Root at an extreme corner, extend toward the opposite corner.
        add_req(make_req(CMD_ROOT, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1'b0, '0));
        add_req(make_req(CMD_EXTEND, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 1'b0, '0));
        // Sample on a node: copy of the node.
        add_req(make_req(CMD_EXTEND, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, '0));
        add_req(make_req(CMD_TRACE, 0, 0, 0, 1'b0, 10'd2));
        add_req(make_req(CMD_TRACE, 0, 0, 0, 1'b0, 10'd3));
        // Root near goal: reached.
        add_req(make_req(CMD_ROOT, 0, 0, 0, 1'b0, '0));
        add_req(make_req(CMD_EXTEND, 65536, 0, 0, 1'b1, '0));
        add_req(make_req(CMD_EXTEND, 0, 10 * 65536, 0, 1'b1, '0));
        add_req(make_req(CMD_EXTEND, 0, 0, -10 * 65536, 1'b0, '0));
        add_req(make_req(CMD_TRACE, 0, 0, 0, 1'b0, 10'd1));
        drain();

        // Budget zero, huge step, zero tolerance.
        write_reg(CFG_BUDGET, 32'd0);
        write_reg(CFG_STEP, 32'h7FFFFFFF);
        write_reg(CFG_TOLERANCE, 32'd0);
        add_req(make_req(CMD_ROOT, 100, 200, 300, 1'b0, '0));
        add_req(make_req(CMD_EXTEND, 0, 0, 0, 1'b1, '0));
        drain();
        write_reg(CFG_BUDGET, 32'd3);
        add_req(make_req(CMD_ROOT, 0, 0, 0, 1'b0, '0));
        for (int i = 0; i < 4; i++)
            add_req(make_req(CMD_EXTEND, 32'sh7FFFFFFF, -5, 32'sh80000000, 1'b1, '0));
        drain();

        // Fill the tree to MAX_NODES with a tiny step, then hit the full case.
        write_reg(CFG_BUDGET, 32'd1022);
        write_reg(CFG_STEP, 32'd1);
        write_reg(CFG_TOLERANCE, 32'd1);
        g = 32'sh40000000;
        write_reg(CFG_GOAL_X, g);
        write_reg(CFG_GOAL_Y, -g);
        write_reg(CFG_GOAL_Z, 32'sh7FFFFFFF);
        add_req(make_req(CMD_ROOT, 0, 0, 0, 1'b0, '0));
        for (int i = 0; i < 513; i++)
            add_req(make_req(CMD_EXTEND, near_coord(), near_coord(), near_coord(), 1'b1, '0));
        // Long receiver hold-off while the sender keeps offering.
        hold_off = 1'b1;
        repeat (4000) @(posedge i_clk);
        hold_off = 1'b0;
        drain();
        add_req(make_req(CMD_TRACE, 0, 0, 0, 1'b0, 10'd1023));
        drain();

        // Random phases over several settings.
        write_reg(CFG_STEP, 32'd65536);
        write_reg(CFG_TOLERANCE, 32'd3 * 65536);
        write_reg(CFG_GOAL_X, 32'd4 * 65536);
        write_reg(CFG_GOAL_Y, 32'd0);
        write_reg(CFG_GOAL_Z, -32'sd2 * 65536);
        write_reg(CFG_BUDGET, 32'd60);
        random_phase(10, 60);
        drain();
        write_reg(CFG_STEP, 32'd4 * 65536);
        write_reg(CFG_TOLERANCE, 32'h7FFFFFFF);
        write_reg(CFG_BUDGET, 32'd10);
        random_phase(5, 10);
        drain();
        write_reg(CFG_STEP, 32'd20000);
        write_reg(CFG_TOLERANCE, 32'd65536);
        write_reg(CFG_BUDGET, 32'd40);
        random_phase(8, 40);
        drain();

        if (failures == 0 && expected_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
